/* rtl/srd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the sum-to-radix-digits block.
// No dependencies; used by srd_ctrl, srd_dpath and sum_to_radix_digits_unit.
package srd_pkg;

    localparam int AddendW   = 30;
    localparam int SumW      = 31;
    localparam int RadixW    = 4;
    localparam int DigitW    = 4;
    localparam int RecipW    = 32;
    localparam int ProdW     = SumW + RecipW;
    localparam int RemW      = 5;
    localparam int MaxDigits = 32;
    localparam int StoreAw   = $clog2(MaxDigits);
    localparam int CountW    = StoreAw + 1;
    localparam int InDataW   = 64;
    localparam int OutDataW  = 8;

    localparam logic [RadixW-1:0] RadixReset = 4'd10;
    localparam logic [RadixW-1:0] RadixMin   = 4'd2;
    localparam logic [RadixW-1:0] RadixMax   = 4'd10;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic fix;
        logic rd_en;
        logic rd_first;
        logic load_out;
    } srd_cmd_t;

    typedef struct packed {
        logic q_zero;
        logic ptr_zero;
    } srd_sts_t;

    // Register values outside 2..10 are clamped.
    function automatic logic [RadixW-1:0] eff_radix(input logic [RadixW-1:0] r);
        logic [RadixW-1:0] res;
        begin
            if (r < RadixMin)
            begin
                res = RadixMin;
            end
            else if (r > RadixMax)
            begin
                res = RadixMax;
            end
            else
            begin
                res = r;
            end
            return res;
        end
    endfunction

    // floor(2^32 / r); quotient estimate is exact or one low.
    function automatic logic [RecipW-1:0] recip(input logic [RadixW-1:0] r);
        logic [RecipW-1:0] m;
        begin
            case (r)
                4'd2:    m = 32'd2147483648;
                4'd3:    m = 32'd1431655765;
                4'd4:    m = 32'd1073741824;
                4'd5:    m = 32'd858993459;
                4'd6:    m = 32'd715827882;
                4'd7:    m = 32'd613566756;
                4'd8:    m = 32'd536870912;
                4'd9:    m = 32'd477218588;
                default: m = 32'd429496729;
            endcase
            return m;
        end
    endfunction

endpackage

/* rtl/srd_ctrl.sv */
`timescale 1ns / 1ps
// Controller FSM: sequences load, divide steps and digit emission.
// Depends on srd_pkg; drives srd_dpath through srd_cmd_t.
module srd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  srd_pkg::srd_sts_t sts,
    output srd_pkg::srd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_PREF,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign fire      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = sts.q_zero ? ST_PREF : ST_MUL;
            end
            ST_PREF:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (fire)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.ptr_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/srd_dpath.sv */
`timescale 1ns / 1ps
// Datapath: adder, reciprocal divide unit, digit store and output register.
// Depends on srd_pkg; commanded by srd_ctrl.
module srd_dpath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [srd_pkg::AddendW-1:0]      addend_a,
    input  logic [srd_pkg::AddendW-1:0]      addend_b,
    input  logic                             cfg_we,
    input  logic [srd_pkg::RadixW-1:0]       cfg_wdata,
    input  srd_pkg::srd_cmd_t                cmd,
    output srd_pkg::srd_sts_t                sts,
    output logic [srd_pkg::DigitW-1:0]       digit,
    output logic                             last
);

    logic [srd_pkg::RadixW-1:0]  radix_reg;
    logic [srd_pkg::RadixW-1:0]  r_eff;
    logic [srd_pkg::SumW-1:0]    work_reg;
    logic [srd_pkg::ProdW-1:0]   prod_reg;
    logic [srd_pkg::CountW-1:0]  count_reg;
    logic [srd_pkg::StoreAw-1:0] ptr_reg;
    logic [srd_pkg::StoreAw-1:0] rd_addr;
    logic [srd_pkg::DigitW-1:0]  rd_data_reg;
    logic [srd_pkg::DigitW-1:0]  digit_reg;
    logic                        last_reg;
    logic [srd_pkg::DigitW-1:0]  store [srd_pkg::MaxDigits];

    logic [srd_pkg::SumW-1:0]    q_est;
    logic [srd_pkg::SumW+srd_pkg::RadixW-1:0] qr;
    logic [srd_pkg::RemW-1:0]    rem_est;
    logic [srd_pkg::RemW-1:0]    r_ext;
    logic                        over;
    logic [srd_pkg::SumW-1:0]    q_fix;
    logic [srd_pkg::DigitW-1:0]  rem_fix;

    assign r_eff   = srd_pkg::eff_radix(radix_reg);
    assign r_ext   = {1'b0, r_eff};
    assign q_est   = prod_reg[srd_pkg::ProdW-1:srd_pkg::RecipW];
    assign qr      = q_est * r_eff;
    // True remainder is below 2*radix, so five low bits suffice.
    assign rem_est = work_reg[srd_pkg::RemW-1:0] - qr[srd_pkg::RemW-1:0];
    assign over    = (rem_est >= r_ext);
    assign q_fix   = over ? q_est + srd_pkg::SumW'(1) : q_est;
    assign rem_fix = over ? srd_pkg::DigitW'(rem_est - r_ext)
                          : srd_pkg::DigitW'(rem_est);

    assign sts.q_zero   = (q_fix == '0);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign rd_addr      = cmd.rd_first ? ptr_reg : ptr_reg - srd_pkg::StoreAw'(1);
    assign digit        = digit_reg;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= srd_pkg::RadixReset;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            if (cmd.load_in)
            begin
                count_reg <= '0;
            end
            else if (cmd.fix)
            begin
                count_reg <= count_reg + srd_pkg::CountW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            work_reg <= srd_pkg::SumW'(addend_a) + srd_pkg::SumW'(addend_b);
        end
        else if (cmd.fix)
        begin
            work_reg <= q_fix;
        end
        if (cmd.mul)
        begin
            prod_reg <= work_reg * srd_pkg::recip(r_eff);
        end
        if (cmd.fix)
        begin
            ptr_reg <= count_reg[srd_pkg::StoreAw-1:0];
        end
        else if (cmd.load_out && !sts.ptr_zero)
        begin
            ptr_reg <= ptr_reg - srd_pkg::StoreAw'(1);
        end
        if (cmd.load_out)
        begin
            digit_reg <= rd_data_reg;
            last_reg  <= sts.ptr_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fix)
        begin
            store[count_reg[srd_pkg::StoreAw-1:0]] <= rem_fix;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

endmodule

/* rtl/sum_to_radix_digits_unit.sv */
`timescale 1ns / 1ps
// Top level: adds two addends and streams the sum as radix digits, MSD first.
// Depends on srd_pkg, srd_ctrl and srd_dpath.
//
// Usage:
//   Input channel s_axis_*: one transfer carries addend_a and addend_b.
//   Output channel m_axis_*: one transfer per digit, most significant first;
//   tlast marks the least significant digit. A zero sum gives one digit 0.
//   cfg_we/cfg_wdata write the radix (reset 10; 0..1 act as 2, 11..15 as 10).
//   Write it only while no item is in flight.
// Timing:
//   The sum is divided by the radix with a reciprocal multiply and a
//   one-step correction, one digit at a time, in a multiply state and a
//   fix state per digit. The most significant digit is then prefetched
//   from the digit store, and digits are presented one per cycle while
//   m_axis_tready is high.
//   The next input transfer is taken once the last digit sits in the
//   output register, while that digit still waits for the receiver.
// Reset: rst_n clears the controller and output valid and sets the radix register to 10.
// Stall: with m_axis_tready low the digit holds and emission pauses.
module sum_to_radix_digits_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [srd_pkg::InDataW-1:0]    s_axis_tdata,  // addend_a[29:0], addend_b[59:30]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [srd_pkg::OutDataW-1:0]   m_axis_tdata,  // digit[3:0]
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [srd_pkg::RadixW-1:0]     cfg_wdata
);

    srd_pkg::srd_cmd_t            cmd;
    srd_pkg::srd_sts_t            sts;
    logic [srd_pkg::DigitW-1:0]   digit;

    srd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srd_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .addend_a  (s_axis_tdata[srd_pkg::AddendW-1:0]),
        .addend_b  (s_axis_tdata[2*srd_pkg::AddendW-1:srd_pkg::AddendW]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .digit     (digit),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(srd_pkg::OutDataW-srd_pkg::DigitW){1'b0}}, digit};

endmodule
